// ----- design/ufsp_pkg.sv -----
// ----------------------------------------------------------------------------
// ufsp_pkg
// Shared types and constants for the union-find site percolation block.
// ----------------------------------------------------------------------------
package ufsp_pkg;

    localparam int MAX_SITES = 4096;
    localparam int ADDR_W    = $clog2(MAX_SITES);
    localparam int SIZE_W    = ADDR_W + 1;
    localparam int SIDE_W    = 7;
    localparam int SIDE_MAX  = 64;
    localparam int REQ_W     = 2;
    localparam int CFG_W     = 32;
    localparam int PADDR_W   = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_OCCUPY = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // one table entry: occupied bit, parent link, size (valid at roots)
    typedef struct packed {
        logic              full;
        logic [ADDR_W-1:0] parent;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_CHK,
        ST_NB,
        ST_NB_CHK,
        ST_WALK,
        ST_CMP,
        ST_MERGE1,
        ST_MERGE2
    } t_state;

    typedef enum logic [1:0] {
        RD_S1,
        RD_NB,
        RD_PARENT,
        RD_START
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_OCCUPY,
        WR_COMPRESS,
        WR_MERGE_ROOT,
        WR_MERGE_LINK
    } t_wr_op;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_ZERO,
        EM_FOUND,
        EM_CLEAR
    } t_emit;

    typedef struct packed {
        t_rd_sel rd_sel;
        t_wr_op  wr_op;
        t_emit   emit;
        logic    latch;
        logic    find_start;
        logic    walk_step;
        logic    top_found;
        logic    cmp_step;
        logic    j_clr;
        logic    j_inc;
        logic    merge;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic s1_ok;
        logic full;
        logic nb_ok;
        logic j_done;
        logic at_top;
        logic cmp_done;
        logic same_root;
        logic clr_last;
    } t_stat;

endpackage

// ----- design/ufsp_dpath.sv -----
// ----------------------------------------------------------------------------
// ufsp_dpath
// Site table memory, walk pointers, merge arithmetic and result registers.
// ----------------------------------------------------------------------------
module ufsp_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ufsp_pkg::t_cmd                 i_cmd,
    output ufsp_pkg::t_stat                o_stat,
    input  logic [ufsp_pkg::SIDE_W-1:0]    i_side,
    input  logic [ufsp_pkg::REQ_W-1:0]     i_req_type,
    input  logic [ufsp_pkg::ADDR_W-1:0]    i_site,
    input  logic [ufsp_pkg::ADDR_W-1:0]    i_neighbor_right,
    input  logic [ufsp_pkg::ADDR_W-1:0]    i_neighbor_down,
    input  logic [ufsp_pkg::ADDR_W-1:0]    i_neighbor_left,
    input  logic [ufsp_pkg::ADDR_W-1:0]    i_neighbor_up,
    output logic                           o_done,
    output logic [ufsp_pkg::ADDR_W-1:0]    o_root,
    output logic                           o_occupied,
    output logic [ufsp_pkg::SIZE_W-1:0]    o_cluster_size,
    output logic [ufsp_pkg::SIZE_W-1:0]    o_largest_size
);
    import ufsp_pkg::*;

    t_entry            mem [MAX_SITES];
    t_entry            r_rdata;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;
    logic              wr_en;

    t_req              r_req;
    logic [ADDR_W-1:0] r_s1;
    logic [ADDR_W-1:0] r_nb [4];
    logic [2:0]        r_j;
    logic [ADDR_W-1:0] r_clr;
    logic [ADDR_W-1:0] r_t;
    logic [ADDR_W-1:0] r_start;
    logic [ADDR_W-1:0] r_v;
    logic [ADDR_W-1:0] r_top;
    logic [SIZE_W-1:0] r_top_size;
    logic [ADDR_W-1:0] r_r1;
    logic [SIZE_W-1:0] r_size1;
    logic [SIZE_W-1:0] r_largest;

    logic [SIDE_W-1:0] side_c;
    logic [SIZE_W-1:0] n_sites;
    logic [ADDR_W-1:0] nb;
    logic              small_first;
    logic [ADDR_W-1:0] winner;
    logic [ADDR_W-1:0] loser;
    logic [SIZE_W-1:0] loser_size;
    logic [SIZE_W-1:0] sum;

    always_comb begin
        if (i_side == '0) begin
            side_c = SIDE_W'(1);
        end else if (i_side > SIDE_W'(SIDE_MAX)) begin
            side_c = SIDE_W'(SIDE_MAX);
        end else begin
            side_c = i_side;
        end
    end

    // 64*64 is exactly the table depth, so no further cap is needed
    assign n_sites     = SIZE_W'(side_c * side_c);
    assign nb          = r_nb[r_j[1:0]];
    assign small_first = r_size1 < r_top_size;
    assign winner      = small_first ? r_top : r_r1;
    assign loser       = small_first ? r_r1 : r_top;
    assign loser_size  = small_first ? r_size1 : r_top_size;
    assign sum         = r_size1 + r_top_size;

    always_comb begin
        o_stat.req       = r_req;
        o_stat.s1_ok     = {1'b0, r_s1} < n_sites;
        o_stat.full      = r_rdata.full;
        o_stat.nb_ok     = (nb != r_s1) && ({1'b0, nb} < n_sites);
        o_stat.j_done    = r_j[2];
        o_stat.at_top    = r_rdata.parent == r_t;
        o_stat.cmp_done  = r_v == r_top;
        o_stat.same_root = r_top == r_r1;
        o_stat.clr_last  = r_clr == ADDR_W'(MAX_SITES - 1);
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_S1:     rd_addr = r_s1;
            RD_NB:     rd_addr = nb;
            RD_PARENT: rd_addr = r_rdata.parent;
            RD_START:  rd_addr = r_start;
            default:   rd_addr = r_s1;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_s1;
        wr_data = '{full: 1'b1, parent: r_s1, size: SIZE_W'(1)};
        case (i_cmd.wr_op)
            WR_CLEAR: begin
                wr_addr = r_clr;
                wr_data = '{full: 1'b0, parent: r_clr, size: '0};
            end
            WR_OCCUPY: begin
                wr_addr = r_s1;
            end
            WR_COMPRESS: begin
                wr_addr = r_v;
                wr_data = '{full: r_rdata.full, parent: r_top, size: r_rdata.size};
            end
            WR_MERGE_ROOT: begin
                wr_addr = winner;
                wr_data = '{full: 1'b1, parent: winner, size: sum};
            end
            WR_MERGE_LINK: begin
                wr_addr = loser;
                wr_data = '{full: 1'b1, parent: winner, size: loser_size};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req   <= t_req'(i_req_type);
            r_s1    <= i_site;
            r_nb[0] <= i_neighbor_right;
            r_nb[1] <= i_neighbor_down;
            r_nb[2] <= i_neighbor_left;
            r_nb[3] <= i_neighbor_up;
        end
        if (i_cmd.find_start) begin
            r_t     <= rd_addr;
            r_start <= rd_addr;
        end
        if (i_cmd.walk_step) begin
            r_t <= r_rdata.parent;
        end
        if (i_cmd.top_found) begin
            r_top      <= r_t;
            r_top_size <= r_rdata.size;
            r_v        <= r_start;
        end
        if (i_cmd.cmp_step) begin
            r_v <= r_rdata.parent;
        end
        if (i_cmd.wr_op == WR_OCCUPY) begin
            r_r1    <= r_s1;
            r_size1 <= SIZE_W'(1);
        end
        if (i_cmd.merge) begin
            r_r1    <= winner;
            r_size1 <= sum;
        end
        case (i_cmd.emit)
            EM_FOUND: begin
                o_root         <= r_top;
                o_occupied     <= 1'b1;
                o_cluster_size <= r_top_size;
                o_largest_size <= r_largest;
            end
            EM_ZERO: begin
                o_root         <= '0;
                o_occupied     <= 1'b0;
                o_cluster_size <= '0;
                o_largest_size <= r_largest;
            end
            EM_CLEAR: begin
                o_root         <= '0;
                o_occupied     <= 1'b0;
                o_cluster_size <= '0;
                o_largest_size <= '0;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j       <= '0;
            r_clr     <= '0;
            r_largest <= '0;
            o_done    <= 1'b0;
        end else begin
            o_done <= i_cmd.emit != EM_NONE;
            if (i_cmd.j_clr) begin
                r_j <= '0;
            end else if (i_cmd.j_inc) begin
                r_j <= r_j + 3'd1;
            end
            // wraps to zero after the last entry, ready for the next sweep
            if (i_cmd.wr_op == WR_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cmd.emit == EM_CLEAR) begin
                r_largest <= '0;
            end else if (i_cmd.merge && (sum > r_largest)) begin
                r_largest <= sum;
            end
        end
    end

endmodule

// ----- design/ufsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ufsp_ctrl
// Sequencer: clearing sweep, occupy over four neighbors, root walk with
// path compression, merge by size.
// ----------------------------------------------------------------------------
module ufsp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output ufsp_pkg::t_cmd  o_cmd,
    input  ufsp_pkg::t_stat i_stat
);
    import ufsp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_final;
    logic   n_final;
    logic   r_emit_clr;
    logic   n_emit_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_final    <= 1'b0;
            r_emit_clr <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_final    <= n_final;
            r_emit_clr <= n_emit_clr;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_final    = r_final;
        n_emit_clr = r_emit_clr;
        o_cmd      = '0;
        o_cmd.rd_sel = RD_S1;
        o_cmd.wr_op  = WR_NONE;
        o_cmd.emit   = EM_NONE;
        o_busy     = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.wr_op = WR_CLEAR;
                if (i_stat.clr_last) begin
                    if (r_emit_clr) begin
                        o_cmd.emit = EM_CLEAR;
                    end
                    n_emit_clr = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_stat.req == REQ_CLEAR) begin
                    n_emit_clr = 1'b1;
                    n_state    = ST_CLEAR;
                end else if ((i_stat.req == REQ_OCCUPY || i_stat.req == REQ_QUERY)
                             && i_stat.s1_ok) begin
                    o_cmd.rd_sel = RD_S1;
                    n_state      = ST_CHK;
                end else begin
                    o_cmd.emit = EM_ZERO;
                    n_state    = ST_IDLE;
                end
            end
            ST_CHK: begin
                if (i_stat.req == REQ_OCCUPY && !i_stat.full) begin
                    o_cmd.wr_op = WR_OCCUPY;
                    o_cmd.j_clr = 1'b1;
                    n_state     = ST_NB;
                end else if (i_stat.full) begin
                    o_cmd.rd_sel     = RD_S1;
                    o_cmd.find_start = 1'b1;
                    n_final          = 1'b1;
                    n_state          = ST_WALK;
                end else begin
                    o_cmd.emit = EM_ZERO;
                    n_state    = ST_IDLE;
                end
            end
            ST_NB: begin
                if (i_stat.j_done) begin
                    o_cmd.rd_sel     = RD_S1;
                    o_cmd.find_start = 1'b1;
                    n_final          = 1'b1;
                    n_state          = ST_WALK;
                end else if (i_stat.nb_ok) begin
                    o_cmd.rd_sel = RD_NB;
                    n_state      = ST_NB_CHK;
                end else begin
                    o_cmd.j_inc = 1'b1;
                end
            end
            ST_NB_CHK: begin
                if (!i_stat.full) begin
                    o_cmd.j_inc = 1'b1;
                    n_state     = ST_NB;
                end else begin
                    o_cmd.rd_sel     = RD_NB;
                    o_cmd.find_start = 1'b1;
                    n_final          = 1'b0;
                    n_state          = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_stat.at_top) begin
                    o_cmd.top_found = 1'b1;
                    o_cmd.rd_sel    = RD_START;
                    n_state         = ST_CMP;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    o_cmd.rd_sel    = RD_PARENT;
                end
            end
            ST_CMP: begin
                if (!i_stat.cmp_done) begin
                    o_cmd.wr_op    = WR_COMPRESS;
                    o_cmd.cmp_step = 1'b1;
                    o_cmd.rd_sel   = RD_PARENT;
                end else if (r_final) begin
                    o_cmd.emit = EM_FOUND;
                    n_state    = ST_IDLE;
                end else if (i_stat.same_root) begin
                    o_cmd.j_inc = 1'b1;
                    n_state     = ST_NB;
                end else begin
                    n_state = ST_MERGE1;
                end
            end
            ST_MERGE1: begin
                o_cmd.wr_op = WR_MERGE_ROOT;
                n_state     = ST_MERGE2;
            end
            ST_MERGE2: begin
                o_cmd.wr_op = WR_MERGE_LINK;
                o_cmd.merge = 1'b1;
                o_cmd.j_inc = 1'b1;
                n_state     = ST_NB;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/union_find_site_percolation.sv -----
// ----------------------------------------------------------------------------
// union_find_site_percolation
// Union-find table over square-lattice sites: clear, occupy with merge by
// size, and root query; occupy and query walks use full path compression.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// request   in         start && !busy          i_req_type, i_site, i_neighbor_*
// result    out        o_done (one cycle)      o_root, o_occupied, o_cluster_size,
//                                              o_largest_size
// config    in         psel&penable&pwrite     paddr, pwdata (lattice_side at 0)
//
// One request at a time on a table memory with a read and a write port
// (one read, one write per cycle, read data registered). Query: read the
// site, walk up to its root, then walk again compressing the path.
// Occupy marks the site, then finds each full neighbor's root and merges by size.
// Clear request and reset: a sweep over every table entry, busy high.
// Result strobe comes in the cycle after the last step; it cannot be stalled.
// ----------------------------------------------------------------------------
module union_find_site_percolation (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ufsp_pkg::REQ_W-1:0]     i_req_type,
    input  logic [ufsp_pkg::ADDR_W-1:0]    i_site,
    input  logic [ufsp_pkg::ADDR_W-1:0]    i_neighbor_right,
    input  logic [ufsp_pkg::ADDR_W-1:0]    i_neighbor_down,
    input  logic [ufsp_pkg::ADDR_W-1:0]    i_neighbor_left,
    input  logic [ufsp_pkg::ADDR_W-1:0]    i_neighbor_up,
    output logic                           o_done,
    output logic [ufsp_pkg::ADDR_W-1:0]    o_root,
    output logic                           o_occupied,
    output logic [ufsp_pkg::SIZE_W-1:0]    o_cluster_size,
    output logic [ufsp_pkg::SIZE_W-1:0]    o_largest_size,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ufsp_pkg::PADDR_W-1:0]   paddr,
    input  logic [ufsp_pkg::CFG_W-1:0]     pwdata,
    output logic [ufsp_pkg::CFG_W-1:0]     prdata,
    output logic                           pready
);
    import ufsp_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic [SIDE_W-1:0] r_side;
    logic              side_sel;

    assign pready   = 1'b1;
    assign side_sel = paddr[PADDR_W-1] == 1'b0;
    assign prdata   = side_sel ? CFG_W'(r_side) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_W'(SIDE_MAX);
        end else if (psel && penable && pwrite && side_sel) begin
            r_side <= pwdata[SIDE_W-1:0];
        end
    end

    ufsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    ufsp_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_side           (r_side),
        .i_req_type       (i_req_type),
        .i_site           (i_site),
        .i_neighbor_right (i_neighbor_right),
        .i_neighbor_down  (i_neighbor_down),
        .i_neighbor_left  (i_neighbor_left),
        .i_neighbor_up    (i_neighbor_up),
        .o_done           (o_done),
        .o_root           (o_root),
        .o_occupied       (o_occupied),
        .o_cluster_size   (o_cluster_size),
        .o_largest_size   (o_largest_size)
    );

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without work in progress");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_occupied) |-> (o_root == '0 && o_cluster_size == '0))
        else $error("empty site reported with root or size");

    a_full_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_occupied) |-> (o_cluster_size != '0))
        else $error("occupied site reported with zero cluster size");
`endif

endmodule

// ----- tb/ufsp_checker.sv -----
// ----------------------------------------------------------------------------
// ufsp_checker
// Watches the request, result and register channels of the union-find block.
// Keeps its own copy of the site table, predicts every result and compares
// the results field by field, oldest expectation first.
// ----------------------------------------------------------------------------
module ufsp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [ufsp_pkg::REQ_W-1:0]    i_req_type,
    input  logic [ufsp_pkg::ADDR_W-1:0]   i_site,
    input  logic [ufsp_pkg::ADDR_W-1:0]   i_neighbor_right,
    input  logic [ufsp_pkg::ADDR_W-1:0]   i_neighbor_down,
    input  logic [ufsp_pkg::ADDR_W-1:0]   i_neighbor_left,
    input  logic [ufsp_pkg::ADDR_W-1:0]   i_neighbor_up,
    input  logic                          i_done,
    input  logic [ufsp_pkg::ADDR_W-1:0]   i_root,
    input  logic                          i_occupied,
    input  logic [ufsp_pkg::SIZE_W-1:0]   i_cluster_size,
    input  logic [ufsp_pkg::SIZE_W-1:0]   i_largest_size,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [ufsp_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [ufsp_pkg::CFG_W-1:0]    i_pwdata,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_results,
    output int                            o_merges,
    output int                            o_peak_largest
);
    timeunit 1ns;
    timeprecision 1ps;
    import ufsp_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_SIDE = '0;

    typedef struct packed {
        logic [ADDR_W-1:0] root;
        logic              occupied;
        logic [SIZE_W-1:0] cluster_size;
        logic [SIZE_W-1:0] largest_size;
    } t_site_report;

    logic [SIDE_W-1:0] side_reg;
    bit                site_full   [MAX_SITES];
    int unsigned       parent_link [MAX_SITES];
    int unsigned       tree_size   [MAX_SITES];
    int unsigned       largest_rec;
    t_site_report      expected_reports[$];

    function automatic int unsigned sites_in_lattice();
        int unsigned s;
        s = side_reg;
        if (s == 0) s = 1;
        if (s > SIDE_MAX) s = SIDE_MAX;
        return (s * s > MAX_SITES) ? MAX_SITES : s * s;
    endfunction

    function automatic void empty_table();
        for (int k = 0; k < MAX_SITES; k++) begin
            site_full[k]   = 1'b0;
            parent_link[k] = k;
            tree_size[k]   = 0;
        end
        largest_rec = 0;
    endfunction

    // root lookup with full path compression
    function automatic int unsigned find_root(int unsigned v);
        int unsigned top;
        int unsigned nxt;
        top = v;
        while (parent_link[top] != top) top = parent_link[top];
        while (v != top) begin
            nxt = parent_link[v];
            parent_link[v] = top;
            v = nxt;
        end
        return top;
    endfunction

    function automatic t_site_report percolate_step(t_req req, int unsigned s1,
                                                    int unsigned nb [4]);
        t_site_report rep;
        int unsigned  n;
        int unsigned  r1;
        int unsigned  r2;
        int unsigned  top;
        rep = '0;
        n = sites_in_lattice();
        if (req == REQ_CLEAR) begin
            empty_table();
        end else if ((req == REQ_OCCUPY || req == REQ_QUERY) && s1 < n) begin
            if (req == REQ_OCCUPY && !site_full[s1]) begin
                r1 = s1;
                site_full[s1]   = 1'b1;
                parent_link[s1] = s1;
                tree_size[s1]   = 1;
                for (int j = 0; j < 4; j++) begin
                    if (nb[j] == s1 || nb[j] >= n || !site_full[nb[j]]) continue;
                    r2 = find_root(nb[j]);
                    if (r2 == r1) continue;
                    if (tree_size[r1] < tree_size[r2]) begin
                        tree_size[r2] += tree_size[r1];
                        parent_link[r1] = r2;
                        r1 = r2;
                    end else begin
                        tree_size[r1] += tree_size[r2];
                        parent_link[r2] = r1;
                    end
                    o_merges++;
                    if (tree_size[r1] > largest_rec) largest_rec = tree_size[r1];
                end
            end
            if (site_full[s1]) begin
                top              = find_root(s1);
                rep.root         = ADDR_W'(top);
                rep.occupied     = 1'b1;
                rep.cluster_size = SIZE_W'(tree_size[top]);
            end
        end
        rep.largest_size = SIZE_W'(largest_rec);
        if (largest_rec > o_peak_largest) o_peak_largest = largest_rec;
        return rep;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results      = 0;
        o_merges       = 0;
        o_peak_largest = 0;
        side_reg       = SIDE_W'(SIDE_MAX);
        empty_table();
    end

    always @(posedge i_clk) begin
        t_site_report want;
        int unsigned  nb [4];
        if (!i_rst_n) begin
            side_reg = SIDE_W'(SIDE_MAX);
            empty_table();
            expected_reports.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_SIDE)
                side_reg = i_pwdata[SIDE_W-1:0];
            if (i_done) begin
                o_results++;
                if (expected_reports.size() == 0) begin
                    report_mismatch("result with no request pending", 1, 0);
                end else begin
                    want = expected_reports.pop_front();
                    if (i_root !== want.root) report_mismatch("root", i_root, want.root);
                    if (i_occupied !== want.occupied)
                        report_mismatch("occupied", i_occupied, want.occupied);
                    if (i_cluster_size !== want.cluster_size)
                        report_mismatch("cluster_size", i_cluster_size, want.cluster_size);
                    if (i_largest_size !== want.largest_size)
                        report_mismatch("largest_size", i_largest_size, want.largest_size);
                end
            end
            if (i_start && !i_busy) begin
                nb[0] = i_neighbor_right;
                nb[1] = i_neighbor_down;
                nb[2] = i_neighbor_left;
                nb[3] = i_neighbor_up;
                expected_reports.push_back(percolate_step(t_req'(i_req_type), i_site, nb));
            end
        end
        o_pending = expected_reports.size();
    end
endmodule

// ----- tb/union_find_site_percolation_tb.sv -----
// ----------------------------------------------------------------------------
// union_find_site_percolation_tb
// Drives directed and random clear/occupy/query/none transactions on lattices of
// several sides through the block, writes the side register between phases,
// and leaves prediction and checking to ufsp_checker.
// ----------------------------------------------------------------------------
module union_find_site_percolation_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ufsp_pkg::*;

    localparam int STALL_LIMIT  = 30000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 140;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [REQ_W-1:0]    req_type = REQ_CLEAR;
    logic [ADDR_W-1:0]   site = '0;
    logic [ADDR_W-1:0]   nb_right = '0;
    logic [ADDR_W-1:0]   nb_down = '0;
    logic [ADDR_W-1:0]   nb_left = '0;
    logic [ADDR_W-1:0]   nb_up = '0;
    logic                done;
    logic [ADDR_W-1:0]   root;
    logic                occupied;
    logic [SIZE_W-1:0]   cluster_size;
    logic [SIZE_W-1:0]   largest_size;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [CFG_W-1:0]    pwdata = '0;
    logic [CFG_W-1:0]    prdata;
    logic                pready;

    int  fail_count, pending, results, merges, peak_largest;
    int  idle_cycles;
    int  lattice_len;
    bit  allow_gaps = 1'b1;

    always #1 i_clk = ~i_clk;

    union_find_site_percolation u_top (
        .i_clk, .i_rst_n, .start, .busy,
        .i_req_type(req_type), .i_site(site),
        .i_neighbor_right(nb_right), .i_neighbor_down(nb_down),
        .i_neighbor_left(nb_left), .i_neighbor_up(nb_up),
        .o_done(done), .o_root(root), .o_occupied(occupied),
        .o_cluster_size(cluster_size), .o_largest_size(largest_size),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    ufsp_checker u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy),
        .i_req_type(req_type), .i_site(site),
        .i_neighbor_right(nb_right), .i_neighbor_down(nb_down),
        .i_neighbor_left(nb_left), .i_neighbor_up(nb_up),
        .i_done(done), .i_root(root), .i_occupied(occupied),
        .i_cluster_size(cluster_size), .i_largest_size(largest_size),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results),
        .o_merges(merges), .o_peak_largest(peak_largest)
    );

    // watchdog: cycles without any transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || done || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send(t_req req, int s, int r, int d, int l, int u);
        int gap;
        start    <= 1'b1;
        req_type <= req;
        site     <= ADDR_W'(s);
        nb_right <= ADDR_W'(r);
        nb_down  <= ADDR_W'(d);
        nb_left  <= ADDR_W'(l);
        nb_up    <= ADDR_W'(u);
        do @(posedge i_clk); while (busy);
        if (allow_gaps && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [PADDR_W-1:0] addr, logic [CFG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_side(int value);
        drain();
        write_reg('0, CFG_W'(value));
        lattice_len = (value == 0) ? 1 : (value > SIDE_MAX ? SIDE_MAX : value);
    endtask

    // occupy with true lattice neighbors; a missing bond points back at the site
    task automatic occupy_lattice(int s);
        int col, row, r, d, l, u;
        col = s % lattice_len;
        row = s / lattice_len;
        r = (col < lattice_len - 1) ? s + 1 : s;
        l = (col > 0) ? s - 1 : s;
        d = (row < lattice_len - 1) ? s + lattice_len : s;
        u = (row > 0) ? s - lattice_len : s;
        send(REQ_OCCUPY, s, r, d, l, u);
    endtask

    task automatic random_item();
        int n, pick, s;
        n = lattice_len * lattice_len;
        pick = $urandom_range(99);
        s = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(n - 1);
        if (pick < 58)
            occupy_lattice(s);
        else if (pick < 88)
            send(REQ_QUERY, s, 0, 0, 0, 0);
        else if (pick < 95)
            send(REQ_OCCUPY, s, $urandom_range(4095), $urandom_range(n - 1),
                 $urandom_range(n - 1), $urandom_range(4095));
        else if (pick < 98)
            send(REQ_NONE, $urandom_range(4095), $urandom_range(4095),
                 $urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
        else
            send(REQ_CLEAR, $urandom_range(4095), 0, 0, 0, 0);
    endtask

    initial begin
        int sides [10] = '{8, 64, 1, 0, 2, 100, 3, 127, 16, 5};
        lattice_len = SIDE_MAX;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset side 64
        send(REQ_QUERY, 5, 0, 0, 0, 0);              // empty site
        send(REQ_OCCUPY, 0, 0, 0, 0, 0);             // no bonds at all
        send(REQ_OCCUPY, 1, 2, 65, 0, 1);            // merge with left
        send(REQ_OCCUPY, 1, 2, 65, 0, 1);            // already occupied
        send(REQ_OCCUPY, 65, 66, 129, 64, 1);
        send(REQ_OCCUPY, 64, 65, 128, 64, 0);        // both bonds hit one cluster
        send(REQ_QUERY, 64, 0, 0, 0, 0);
        send(REQ_OCCUPY, 4095, 4095, 4095, 4094, 4031);
        send(REQ_OCCUPY, 4094, 4095, 4094, 4093, 4030);
        send(REQ_OCCUPY, 2730, 1365, 4095, 2729, 2666);
        send(REQ_NONE, 4095, 4095, 4095, 4095, 4095);
        send(REQ_QUERY, 4095, 0, 0, 0, 0);
        send(REQ_CLEAR, 0, 0, 0, 0, 0);
        send(REQ_QUERY, 1, 0, 0, 0, 0);
        set_side(2);                                  // out-of-range sites and bonds
        send(REQ_OCCUPY, 0, 1, 2, 4, 4095);
        send(REQ_OCCUPY, 3, 3, 3, 2, 1);
        send(REQ_OCCUPY, 1, 1, 3, 0, 1);
        send(REQ_OCCUPY, 4, 3, 0, 0, 0);
        send(REQ_QUERY, 4095, 0, 0, 0, 0);
        send(REQ_QUERY, 0, 0, 0, 0, 0);
        drain();
        write_reg(PADDR_W'(4), 32'h7F);               // unmapped register

        foreach (sides[p]) begin
            if (p == $size(sides) - 1) allow_gaps = 1'b0;
            set_side(sides[p]);
            if ($urandom_range(1)) send(REQ_CLEAR, 0, 0, 0, 0, 0);
            repeat (PHASE_ITEMS) random_item();
        end

        drain();
        $display("covered %0d result transactions over 10 lattice sides, %0d cluster merges,",
                 results, merges);
        $display("largest recorded cluster %0d sites", peak_largest);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
design/ufsp_pkg.sv
design/ufsp_dpath.sv
design/ufsp_ctrl.sv
design/union_find_site_percolation.sv
tb/ufsp_checker.sv
tb/union_find_site_percolation_tb.sv
